[rtl/core/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and the control program of the preemptive
// priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Wait queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operation codes of a command beat
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // One wait queue entry
  typedef struct packed {
    logic [7:0]  id;
    logic [3:0]  prio;
    logic [15:0] left;
  } pps_entry_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_CLEAR,
    ACT_SCAN_START,
    ACT_SCAN,
    ACT_TAKE,
    ACT_SHIFT,
    ACT_POP,
    ACT_DEC,
    ACT_ARRIVE,
    ACT_PUBLISH
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_ARRIVAL,
    COND_KEEP_RUN,
    COND_EMPTY,
    COND_SCAN_MORE,
    COND_SHIFT_MORE,
    COND_OUT_BUSY
  } cond_t;

  // Program step addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_DECODE  = 4'd1;
  localparam step_t S_TCHK    = 4'd2;
  localparam step_t S_TEMPTY  = 4'd3;
  localparam step_t S_SCAN0   = 4'd4;
  localparam step_t S_SCAN    = 4'd5;
  localparam step_t S_TAKE    = 4'd6;
  localparam step_t S_SHIFT   = 4'd7;
  localparam step_t S_POP     = 4'd8;
  localparam step_t S_DEC     = 4'd9;
  localparam step_t S_ARR     = 4'd10;
  localparam step_t S_WAIT    = 4'd11;
  localparam step_t S_OUT     = 4'd12;

  // Control word: action, jump condition, jump target
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } pps_cw_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_fire;
    logic arrival;
    logic keep_run;
    logic empty;
    logic scan_more;
    logic shift_more;
    logic out_busy;
  } pps_flags_t;

  // Control program
  function automatic pps_cw_t pps_rom(input step_t s);
    pps_cw_t cw;
    cw = '{act: ACT_NONE, cond: COND_ALWAYS, target: S_IDLE};
    case (s)
      S_IDLE:   cw = '{act: ACT_LATCH,      cond: COND_NO_IN,      target: S_IDLE};
      S_DECODE: cw = '{act: ACT_NONE,       cond: COND_ARRIVAL,    target: S_ARR};
      S_TCHK:   cw = '{act: ACT_NONE,       cond: COND_KEEP_RUN,   target: S_DEC};
      S_TEMPTY: cw = '{act: ACT_CLEAR,      cond: COND_EMPTY,      target: S_DEC};
      S_SCAN0:  cw = '{act: ACT_SCAN_START, cond: COND_NEVER,      target: S_IDLE};
      S_SCAN:   cw = '{act: ACT_SCAN,       cond: COND_SCAN_MORE,  target: S_SCAN};
      S_TAKE:   cw = '{act: ACT_TAKE,       cond: COND_NEVER,      target: S_IDLE};
      S_SHIFT:  cw = '{act: ACT_SHIFT,      cond: COND_SHIFT_MORE, target: S_SHIFT};
      S_POP:    cw = '{act: ACT_POP,        cond: COND_NEVER,      target: S_IDLE};
      S_DEC:    cw = '{act: ACT_DEC,        cond: COND_ALWAYS,     target: S_WAIT};
      S_ARR:    cw = '{act: ACT_ARRIVE,     cond: COND_NEVER,      target: S_IDLE};
      S_WAIT:   cw = '{act: ACT_NONE,       cond: COND_OUT_BUSY,   target: S_WAIT};
      S_OUT:    cw = '{act: ACT_PUBLISH,    cond: COND_ALWAYS,     target: S_IDLE};
      default:  cw = '{act: ACT_NONE,       cond: COND_ALWAYS,     target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

[rtl/core/pps_cmd_if.sv]
// ----------------------------------------------------------------------------
// pps_cmd_if
// Command channel: one tick or one task arrival per beat.
// ----------------------------------------------------------------------------
interface pps_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  task_id;
  logic [3:0]  task_priority;
  logic [15:0] task_time;

  modport source (output valid, opcode, task_id, task_priority, task_time, input ready);
  modport sink   (input valid, opcode, task_id, task_priority, task_time, output ready);
endinterface

[rtl/core/pps_status_if.sv]
// ----------------------------------------------------------------------------
// pps_status_if
// Status channel: running task after each command beat.
// ----------------------------------------------------------------------------
interface pps_status_if;
  logic        valid;
  logic        ready;
  logic        run_valid;
  logic [7:0]  run_id;
  logic [15:0] run_left;
  logic        dropped;

  modport source (output valid, run_valid, run_id, run_left, dropped, input ready);
  modport sink   (input valid, run_valid, run_id, run_left, dropped, output ready);
endinterface

[rtl/core/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pps_seq.sv]
// ----------------------------------------------------------------------------
// pps_seq
// Step counter and control store: fetch one control word per cycle and
// branch on datapath flags.
// ----------------------------------------------------------------------------
module pps_seq (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::pps_flags_t flags,
  output pps_pkg::pps_cw_t    cw
);
  import pps_pkg::*;

  step_t step;
  step_t step_next;
  logic  take_jump;

  // Fetch the control word of the current step
  assign cw = pps_rom(step);

  // Evaluate the jump condition
  always_comb begin
    case (cw.cond)
      COND_NEVER:      take_jump = 1'b0;
      COND_ALWAYS:     take_jump = 1'b1;
      COND_NO_IN:      take_jump = !flags.in_fire;
      COND_ARRIVAL:    take_jump = flags.arrival;
      COND_KEEP_RUN:   take_jump = flags.keep_run;
      COND_EMPTY:      take_jump = flags.empty;
      COND_SCAN_MORE:  take_jump = flags.scan_more;
      COND_SHIFT_MORE: take_jump = flags.shift_more;
      COND_OUT_BUSY:   take_jump = flags.out_busy;
      default:         take_jump = 1'b0;
    endcase
  end

  // Branch or advance
  always_comb begin
    step_next = take_jump ? cw.target : step_t'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[rtl/core/pps_datapath.sv]
// ----------------------------------------------------------------------------
// pps_datapath
// Running task registers, wait queue memory, scan and shift datapath and
// the command and status channel registers, all driven by the control word.
// ----------------------------------------------------------------------------
module pps_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::pps_cw_t    cw,
  output pps_pkg::pps_flags_t flags,
  pps_cmd_if.sink             cmd,
  pps_status_if.source        status
);
  import pps_pkg::*;

  // Latched command
  logic        op;
  pps_entry_t  arr_ent;

  // Running task
  logic        run_valid;
  logic [7:0]  run_id;
  logic [3:0]  run_prio;
  logic [15:0] run_left;

  // Queue bookkeeping and scan state
  cnt_t        count;
  cnt_t        idx;
  cnt_t        scan_pos;
  idx_t        best;
  logic [3:0]  best_prio;
  pps_entry_t  best_ent;
  logic        dropped;

  // Status register
  logic        st_valid;
  logic        st_run_valid;
  logic [7:0]  st_run_id;
  logic [15:0] st_run_left;
  logic        st_dropped;

  // Queue memory ports
  logic        q_we;
  idx_t        q_waddr;
  pps_entry_t  q_wdata;
  idx_t        q_raddr;
  pps_entry_t  q_rdata;

  logic        in_fire;
  logic        not_full;
  logic        preempt;
  logic        shift_more;
  pps_entry_t  run_ent;

  pps_ram #(
    .WIDTH ($bits(pps_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Handshake and flag logic
  assign cmd.ready  = (cw.act == ACT_LATCH);
  assign in_fire    = cmd.valid && cmd.ready;
  assign not_full   = (count < cnt_t'(QUEUE_DEPTH));
  assign preempt    = run_valid && (arr_ent.prio > run_prio);
  assign shift_more = (({1'b0, idx} + 1'b1) < {1'b0, count});
  assign scan_pos   = cnt_t'(idx - 1'b1);
  assign run_ent    = '{id: run_id, prio: run_prio, left: run_left};

  always_comb begin
    flags.in_fire    = in_fire;
    flags.arrival    = (op == OP_ARRIVE);
    flags.keep_run   = run_valid && (run_left != 16'd0);
    flags.empty      = (count == '0);
    flags.scan_more  = (idx < count);
    flags.shift_more = shift_more;
    flags.out_busy   = st_valid && !status.ready;
  end

  // Queue memory addressing
  always_comb begin
    q_we    = 1'b0;
    q_waddr = idx_t'(count);
    q_wdata = arr_ent;
    q_raddr = '0;
    case (cw.act)
      ACT_SCAN: begin
        q_raddr = idx_t'(idx);
      end
      ACT_TAKE: begin
        q_raddr = idx_t'(cnt_t'(best) + 1'b1);
      end
      ACT_SHIFT: begin
        q_we    = shift_more;
        q_waddr = idx_t'(idx);
        q_wdata = q_rdata;
        q_raddr = idx_t'(idx + cnt_t'(2));
      end
      ACT_ARRIVE: begin
        q_we    = run_valid && not_full;
        q_wdata = preempt ? run_ent : arr_ent;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  // Command latch, running task, scan registers, queue count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      run_valid <= 1'b0;
      run_id    <= '0;
      run_prio  <= '0;
      run_left  <= '0;
    end else begin
      case (cw.act)
        ACT_LATCH: begin
          dropped <= 1'b0;
          if (in_fire) begin
            op      <= cmd.opcode;
            arr_ent <= '{id: cmd.task_id, prio: cmd.task_priority, left: cmd.task_time};
          end
        end
        ACT_CLEAR: begin
          run_valid <= 1'b0;
          run_id    <= '0;
          run_prio  <= '0;
          run_left  <= '0;
        end
        ACT_SCAN_START: begin
          idx       <= cnt_t'(1);
          best      <= '0;
          best_prio <= '0;
        end
        ACT_SCAN: begin
          // keep the last entry that holds the highest priority
          if (q_rdata.prio >= best_prio) begin
            best      <= idx_t'(scan_pos);
            best_prio <= q_rdata.prio;
            best_ent  <= q_rdata;
          end
          idx <= cnt_t'(idx + 1'b1);
        end
        ACT_TAKE: begin
          run_valid <= 1'b1;
          run_id    <= best_ent.id;
          run_prio  <= best_ent.prio;
          run_left  <= best_ent.left;
          idx       <= cnt_t'(best);
        end
        ACT_SHIFT: begin
          idx <= cnt_t'(idx + 1'b1);
        end
        ACT_POP: begin
          count <= cnt_t'(count - 1'b1);
        end
        ACT_DEC: begin
          if (run_valid && (run_left != 16'd0)) begin
            run_left <= run_left - 16'd1;
          end
        end
        ACT_ARRIVE: begin
          if (!run_valid || preempt) begin
            run_valid <= 1'b1;
            run_id    <= arr_ent.id;
            run_prio  <= arr_ent.prio;
            run_left  <= arr_ent.left;
          end
          if (run_valid) begin
            if (not_full) begin
              count <= cnt_t'(count + 1'b1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        default: begin
          dropped <= dropped;
        end
      endcase
    end
  end

  // Status register: load on publish, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (cw.act == ACT_PUBLISH) begin
      st_valid <= 1'b1;
    end else if (status.ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_PUBLISH) begin
      st_run_valid <= run_valid;
      st_run_id    <= run_valid ? run_id : 8'd0;
      st_run_left  <= run_valid ? run_left : 16'd0;
      st_dropped   <= dropped;
    end
  end

  assign status.valid     = st_valid;
  assign status.run_valid = st_run_valid;
  assign status.run_id    = st_run_id;
  assign status.run_left  = st_run_left;
  assign status.dropped   = st_dropped;

endmodule

[rtl/core/preemptive_priority_scheduler_top.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Preemptive priority scheduler with a wait queue held in RAM.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time on cmd (a tick or a task
// arrival) and returns one status beat on status with the running task after
// that command and a flag for a task lost to a full queue. A microcoded
// sequencer steps a small datapath; the wait queue is a single-port-write,
// single-port-read RAM, so queue work goes one entry per cycle. A tick that
// must pick a new task scans every queued entry and then shifts the entries
// behind the chosen one down. A waiting status beat that is not taken holds
// the sequencer before its next publish. Queue entries past the fill count
// are never used, so the RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top (
  input  logic         clk,
  input  logic         rst,
  pps_cmd_if.sink      cmd,
  pps_status_if.source status
);
  import pps_pkg::*;

  pps_cw_t    cw;
  pps_flags_t flags;

  pps_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  pps_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cw     (cw),
    .flags  (flags),
    .cmd    (cmd),
    .status (status)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority scheduler. A directed
// sequence covers empty ticks, zero-time tasks, preemption, priority ties,
// a full wait queue and a preempting arrival on a full queue. Random command
// beats with shifting tick/arrival mixes follow. A cycle-free model of the
// scheduler predicts every status beat, and a checker compares each one
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pps_pkg::*;

  localparam int RANDOM_ITEMS    = 850;
  localparam int PHASE_ITEMS     = 100;
  localparam int DRAIN_AT        = 400;
  localparam int HOLD_AT_RESULTS = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int QUIET_LIMIT     = 5000;

  // One expected or observed status beat
  typedef struct packed {
    logic        run_valid;
    logic [7:0]  run_id;
    logic [15:0] run_left;
    logic        dropped;
  } status_beat_t;

  // Scheduler model and status checker
  class sched_checker;
    bit              cur_on;
    logic [7:0]      cur_id;
    logic [3:0]      cur_pri;
    logic [15:0]     cur_rem;
    pps_entry_t      waitq[$];
    status_beat_t    status_due[$];
    int              errors;
    int              checked;

    function new();
      cur_on  = 1'b0;
      cur_id  = '0;
      cur_pri = '0;
      cur_rem = '0;
      errors  = 0;
      checked = 0;
    endfunction

    // Append at the tail; report a loss when the queue is full
    function bit park(logic [7:0] id, logic [3:0] pri, logic [15:0] t);
      if (waitq.size() >= QUEUE_DEPTH) return 1'b0;
      waitq.push_back('{id: id, prio: pri, left: t});
      return 1'b1;
    endfunction

    // Advance the model by one accepted command beat
    function void apply_command(logic op, logic [7:0] id, logic [3:0] pri,
                                logic [15:0] t);
      bit           lost;
      int           pick;
      status_beat_t beat;
      lost = 1'b0;
      if (op == OP_ARRIVE) begin
        if (!cur_on) begin
          cur_on  = 1'b1;
          cur_id  = id;
          cur_pri = pri;
          cur_rem = t;
        end else if (pri > cur_pri) begin
          lost    = !park(cur_id, cur_pri, cur_rem);
          cur_id  = id;
          cur_pri = pri;
          cur_rem = t;
        end else begin
          lost = !park(id, pri, t);
        end
      end else begin
        // Replace a finished or absent task with the last top-priority entry
        if (!cur_on || cur_rem == 16'd0) begin
          if (waitq.size() == 0) begin
            cur_on  = 1'b0;
            cur_id  = '0;
            cur_pri = '0;
            cur_rem = '0;
          end else begin
            pick = 0;
            for (int i = 1; i < waitq.size(); i++)
              if (waitq[i].prio >= waitq[pick].prio) pick = i;
            cur_on  = 1'b1;
            cur_id  = waitq[pick].id;
            cur_pri = waitq[pick].prio;
            cur_rem = waitq[pick].left;
            waitq.delete(pick);
          end
        end
        // Count down, saturating at zero
        if (cur_on && cur_rem != 16'd0) cur_rem = cur_rem - 16'd1;
      end
      beat.run_valid = cur_on;
      beat.run_id    = cur_on ? cur_id : 8'd0;
      beat.run_left  = cur_on ? cur_rem : 16'd0;
      beat.dropped   = lost;
      status_due.push_back(beat);
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    // Match one status beat against the oldest prediction
    function void check_status(status_beat_t got);
      status_beat_t want;
      checked++;
      if (status_due.size() == 0) begin
        $display("%0t: unexpected status beat: expected none, actual %0b/%0d/%0d/%0b",
                 $time, got.run_valid, got.run_id, got.run_left, got.dropped);
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare("run_valid", 16'(want.run_valid), 16'(got.run_valid));
      compare("run_id",    16'(want.run_id),    16'(got.run_id));
      compare("run_left",  want.run_left,       got.run_left);
      compare("dropped",   16'(want.dropped),   16'(got.dropped));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  int           quiet_cycles = 0;
  sched_checker sb = new();

  pps_cmd_if    cmd_bus ();
  pps_status_if status_bus ();

  preemptive_priority_scheduler_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .status (status_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe both channels; count cycles with no beat on either
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready)
        sb.apply_command(cmd_bus.opcode, cmd_bus.task_id, cmd_bus.task_priority,
                         cmd_bus.task_time);
      if (status_bus.valid && status_bus.ready)
        sb.check_status('{run_valid: status_bus.run_valid, run_id: status_bus.run_id,
                          run_left: status_bus.run_left, dropped: status_bus.dropped});
      if ((cmd_bus.valid && cmd_bus.ready) || (status_bus.valid && status_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Abort a hung run
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Status receiver: stall in stretches of random style, one long hold-off
  initial begin
    int mode;
    int stretch;
    bit held;
    held = 1'b0;
    status_bus.ready <= 1'b0;
    forever begin
      if (!held && sb.checked >= HOLD_AT_RESULTS) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          status_bus.ready <= 1'b0;
        end
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(8, 64);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: status_bus.ready <= 1'b1;
          1: status_bus.ready <= ($urandom_range(0, 3) != 0);
          2: status_bus.ready <= ($urandom_range(0, 3) == 0);
          default: status_bus.ready <= ~status_bus.ready;
        endcase
      end
    end
  end

  // Drive one command beat and hold it until accepted
  task automatic send_command(input logic op, input logic [7:0] id,
                              input logic [3:0] pri, input logic [15:0] t);
    cmd_bus.valid         <= 1'b1;
    cmd_bus.opcode        <= op;
    cmd_bus.task_id       <= id;
    cmd_bus.task_priority <= pri;
    cmd_bus.task_time     <= t;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Stop offering and wait until every status beat is back
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.status_due.size() != 0);
  endtask

  initial begin
    int          sent;
    int          next_phase;
    int          tick_pct;
    int          burst;
    int          gap;
    int          sel;
    bit          drained;
    logic        op;
    logic [3:0]  pri;
    logic [15:0] t;

    rst                   <= 1'b1;
    cmd_bus.valid         <= 1'b0;
    cmd_bus.opcode        <= OP_TICK;
    cmd_bus.task_id       <= '0;
    cmd_bus.task_priority <= '0;
    cmd_bus.task_time     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tick, zero-time task, tie, preemption, saturation
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    send_command(OP_ARRIVE, 8'd0,   4'd0,  16'd0);
    send_command(OP_ARRIVE, 8'd1,   4'd0,  16'd5);
    send_command(OP_ARRIVE, 8'd2,   4'd3,  16'd2);
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    // Fill the queue with equal-priority tasks, then overflow it
    for (int k = 0; k < QUEUE_DEPTH + 1; k++)
      send_command(OP_ARRIVE, 8'(16 + k), 4'd0, 16'(k + 1));
    // Preempt on a full queue: the running task is lost
    send_command(OP_ARRIVE, 8'd255, 4'd15, 16'hFFFF);
    send_command(OP_TICK,   8'd0,   4'd0,  16'd0);
    wait_drained();

    // Random bursts with a changing tick/arrival mix
    sent       = 0;
    next_phase = 0;
    tick_pct   = 50;
    drained    = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_phase) begin
        next_phase += PHASE_ITEMS;
        case ($urandom_range(0, 2))
          0: tick_pct = 15;
          1: tick_pct = 45;
          default: tick_pct = 75;
        endcase
      end
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        op  = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_ARRIVE;
        // Favor the priority extremes to provoke ties
        pri = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 1) * 15)
                                          : 4'($urandom_range(0, 15));
        // Mostly short tasks so they finish and get replaced
        sel = $urandom_range(0, 15);
        if (sel < 10)      t = 16'($urandom_range(0, 3));
        else if (sel < 13) t = 16'($urandom_range(4, 40));
        else if (sel < 15) t = 16'($urandom());
        else               t = 16'hFFFF;
        send_command(op, 8'($urandom_range(0, 255)), pri, t);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (!drained && sent >= DRAIN_AT) begin
        drained = 1'b1;
        wait_drained();
      end
    end

    // Let the last beats return, then give stray beats a chance to show
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.status_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
